[hdl/spc_pkg.sv]
// shared types and constants of the steering position corrector
package spc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CUR_W      = 6;
   localparam int STEP_W     = 24;
   localparam int SPEED_W    = 16;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 3;

   localparam logic [CUR_W-1:0] HOLD_CURRENT_ON = 6'd5;
   localparam logic [CUR_W-1:0] RUN_CURRENT_ON  = 6'd50;
   localparam logic [CUR_W-1:0] CURRENT_OFF     = 6'd0;

   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_TARGET = 1'b1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_OFFSET   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEPS_PER_REV  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_THRESH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_DBAND   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SMALL_MOVE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_LIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ERROR      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CORRECTION = 3'd7;

   // decisions made in the tracking stage, carried to the correction stage
   typedef struct packed {
      logic motor_enabled;
      logic current_update;
      logic set_actual;
      logic set_target;
      logic big_error;
   } spc_flags_type;

endpackage

[hdl/spc_track.sv]
// tracking stage: target capture, enable, stall counting and the two step products
module spc_track
   import spc_pkg::*;
#(
   parameter int ANGLE_BITS       = 12,
   parameter int STALL_COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              advance,
   input  logic                              kind,
   input  logic [ANGLE_BITS-1:0]             sensor_raw,
   input  logic signed [ANGLE_BITS-1:0]      target_angle,
   input  logic signed [SPEED_W-1:0]         car_speed,
   input  logic [11:0]                       angle_offset,
   input  logic [15:0]                       steps_per_rev_geared,
   input  logic [14:0]                       speed_threshold,
   input  logic [10:0]                       target_deadband,
   input  logic [10:0]                       small_move_threshold,
   input  logic [15:0]                       stall_limit,
   input  logic [11:0]                       max_error,
   output spc_flags_type                     flags_ff,
   output logic signed [ANGLE_BITS+16:0]     prod_cur_ff,
   output logic signed [ANGLE_BITS+16:0]     prod_err_ff
);

   localparam int A  = ANGLE_BITS;
   localparam int PW = ANGLE_BITS + 17;
   localparam int DW = (ANGLE_BITS + 2 > 13) ? ANGLE_BITS + 2 : 13;
   localparam int SW = STALL_COUNT_BITS;
   localparam int CW = (STALL_COUNT_BITS > 16) ? STALL_COUNT_BITS : 16;

   logic signed [A-1:0]  held_ff, held_in;
   logic signed [A-1:0]  prev_ff, prev_in;
   logic [SW-1:0]        stall_ff, stall_in;
   logic                 en_ff, en_in;

   logic [A-1:0]         off_a;
   logic signed [A-1:0]  cur, nt, err;
   logic signed [DW-1:0] d_tgt, d_move, d_err;
   logic [DW-1:0]        a_tgt, a_move, a_err;
   logic signed [SPEED_W:0] spd_ext;
   logic [SPEED_W:0]     a_spd;
   logic                 want;
   logic [SW-1:0]        stall_next;
   logic                 resync;
   logic signed [16:0]   spr_s;
   spc_flags_type        flags_in;
   logic signed [PW-1:0] prod_cur_in, prod_err_in;

   assign off_a = A'(angle_offset);
   assign cur   = $signed(sensor_raw - off_a);
   assign nt    = -target_angle;
   assign err   = held_ff - cur;

   assign d_tgt  = DW'(nt) - DW'(held_ff);
   assign d_move = DW'(cur) - DW'(prev_ff);
   assign d_err  = DW'(err);
   assign a_tgt  = d_tgt[DW-1]  ? $unsigned(-d_tgt)  : $unsigned(d_tgt);
   assign a_move = d_move[DW-1] ? $unsigned(-d_move) : $unsigned(d_move);
   assign a_err  = d_err[DW-1]  ? $unsigned(-d_err)  : $unsigned(d_err);

   assign spd_ext = (SPEED_W+1)'(car_speed);
   assign a_spd   = spd_ext[SPEED_W] ? $unsigned(-spd_ext) : $unsigned(spd_ext);
   assign want    = a_spd > (SPEED_W+1)'(speed_threshold);

   // stall counter saturates at all ones
   always_comb begin
      if (a_move < DW'(small_move_threshold)) begin
         stall_next = (stall_ff == {SW{1'b1}}) ? stall_ff : stall_ff + 1'b1;
      end else begin
         stall_next = '0;
      end
   end
   assign resync = CW'(stall_next) > CW'(stall_limit);

   assign spr_s       = $signed({1'b0, steps_per_rev_geared});
   assign prod_cur_in = PW'(cur) * PW'(spr_s);
   assign prod_err_in = PW'(err) * PW'(spr_s);

   always_comb begin
      held_in  = held_ff;
      prev_in  = prev_ff;
      stall_in = stall_ff;
      en_in    = en_ff;
      flags_in = '0;
      if (kind == KIND_TARGET) begin
         if (a_tgt >= DW'(target_deadband)) begin
            held_in             = nt;
            flags_in.set_actual = 1'b1;
         end
      end else begin
         en_in                   = want;
         flags_in.current_update = (want != en_ff);
         if (want) begin
            prev_in             = cur;
            stall_in            = resync ? '0 : stall_next;
            flags_in.set_actual = resync;
            flags_in.set_target = 1'b1;
            flags_in.big_error  = a_err > DW'(max_error);
         end
      end
      flags_in.motor_enabled = en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         prev_ff  <= '0;
         stall_ff <= '0;
         en_ff    <= 1'b0;
      end else if (accept) begin
         held_ff  <= held_in;
         prev_ff  <= prev_in;
         stall_ff <= stall_in;
         en_ff    <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff    <= flags_in;
         prod_cur_ff <= prod_cur_in;
         prod_err_ff <= prod_err_in;
      end
   end

endmodule

[hdl/spc_corr.sv]
// correction stage: products to steps, 1.5x gain, clamp and target sum
module spc_corr
   import spc_pkg::*;
#(
   parameter int ANGLE_BITS = 12
) (
   input  spc_flags_type                 flags,
   input  logic signed [ANGLE_BITS+16:0] prod_cur,
   input  logic signed [ANGLE_BITS+16:0] prod_err,
   input  logic [15:0]                   max_correction,
   output logic signed [STEP_W-1:0]      actual_steps,
   output logic signed [STEP_W-1:0]      target_steps
);

   localparam int A  = ANGLE_BITS;
   localparam int PW = ANGLE_BITS + 17;

   logic signed [PW-1:0] rc, re;
   logic signed [PW-1:0] sc_full, se_full;
   logic signed [16:0]   cs, ce;
   logic signed [18:0]   c3;
   logic signed [18:0]   c3r;
   logic signed [18:0]   half;
   logic signed [18:0]   lim;
   logic signed [18:0]   clamped;
   logic signed [18:0]   tsum;

   // division by a revolution, truncated toward zero
   assign rc      = prod_cur + (prod_cur[PW-1] ? PW'((1 << A) - 1) : PW'(0));
   assign re      = prod_err + (prod_err[PW-1] ? PW'((1 << A) - 1) : PW'(0));
   assign sc_full = rc >>> A;
   assign se_full = re >>> A;
   assign cs      = sc_full[16:0];
   assign ce      = se_full[16:0];

   // times three, halved toward zero
   assign c3   = 19'(ce) + (19'(ce) <<< 1);
   assign c3r  = c3 + (c3[18] ? 19'sd1 : 19'sd0);
   assign half = c3r >>> 1;
   assign lim  = $signed({3'b000, max_correction});

   always_comb begin
      if (half > lim) begin
         clamped = lim;
      end else if (half < -lim) begin
         clamped = -lim;
      end else begin
         clamped = half;
      end
      tsum = flags.big_error ? 19'(cs) + clamped : 19'(cs);
   end

   assign actual_steps = flags.set_actual ? STEP_W'(cs) : '0;
   assign target_steps = flags.set_target ? STEP_W'(tsum) : '0;

endmodule

[hdl/steering_position_corrector_top.sv]
// top level of the steering position corrector: csr bank, pipeline control, result register
//
// channel   direction  handshake            payload
// req       in         req_tvalid/tready    tdata sensor_raw, target_angle, car_speed; tuser kind
// rsp       out        rsp_tvalid/tready    tdata enable and currents, steps; tuser update flags
// csr       in         csr_we               csr_index, csr_wdata
//
// one item per cycle while the output is not held; the tracking registers load at the
// transfer and the correction logic feeds the result register behind rsp_tvalid. the
// steering state updates at the transfer, so back-to-back items see each other's effects.
// synchronous reset clears state and valid flags, sets csr defaults.
// while a result waits on rsp_tready the whole pipeline holds and req_tready drops.
module steering_position_corrector_top
   import spc_pkg::*;
#(
   parameter int ANGLE_BITS       = 12,
   parameter int STALL_COUNT_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // sensor_raw, target_angle, car_speed, zero fill
   input  logic [((2*ANGLE_BITS+SPEED_W+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic                                      req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // motor_enabled, hold_current, run_current, actual_steps, target_steps, zero fill
   output logic [RSP_DATA_W-1:0]                     rsp_tdata,
   // current_update, set_actual, set_target
   output logic [RSP_USER_W-1:0]                     rsp_tuser,
   input  logic                                      csr_we,
   input  logic [CSR_IDX_W-1:0]                      csr_index,
   input  logic [CSR_DATA_W-1:0]                     csr_wdata
);

   localparam int A  = ANGLE_BITS;
   localparam int PW = ANGLE_BITS + 17;

   logic [11:0] angle_offset_ff;
   logic [15:0] steps_per_rev_ff;
   logic [14:0] speed_threshold_ff;
   logic [10:0] target_deadband_ff;
   logic [10:0] small_move_ff;
   logic [15:0] stall_limit_ff;
   logic [11:0] max_error_ff;
   logic [15:0] max_correction_ff;

   logic                     advance;
   logic                     accept;
   logic                     s1_valid_ff;
   spc_flags_type            s1_flags;
   logic signed [PW-1:0]     s1_prod_cur, s1_prod_err;
   logic signed [STEP_W-1:0] actual_steps, target_steps;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]    rsp_user_ff, rsp_user_in;
   logic [CUR_W-1:0]         hold_current, run_current;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_offset_ff    <= 12'd0;
         steps_per_rev_ff   <= 16'd3200;
         speed_threshold_ff <= 15'd10;
         target_deadband_ff <= 11'd1;
         small_move_ff      <= 11'd2;
         stall_limit_ff     <= 16'd50;
         max_error_ff       <= 12'd23;
         max_correction_ff  <= 16'd200;
      end else if (csr_we) begin
         case (csr_index)
            REG_ANGLE_OFFSET:   angle_offset_ff    <= csr_wdata[11:0];
            REG_STEPS_PER_REV:  steps_per_rev_ff   <= csr_wdata[15:0];
            REG_SPEED_THRESH:   speed_threshold_ff <= csr_wdata[14:0];
            REG_TARGET_DBAND:   target_deadband_ff <= csr_wdata[10:0];
            REG_SMALL_MOVE:     small_move_ff      <= csr_wdata[10:0];
            REG_STALL_LIMIT:    stall_limit_ff     <= csr_wdata[15:0];
            REG_MAX_ERROR:      max_error_ff       <= csr_wdata[11:0];
            REG_MAX_CORRECTION: max_correction_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a result is stuck at the output
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   spc_track #(
      .ANGLE_BITS       (ANGLE_BITS),
      .STALL_COUNT_BITS (STALL_COUNT_BITS)
   ) u_track (
      .clock                (clock),
      .reset                (reset),
      .accept               (accept),
      .advance              (advance),
      .kind                 (req_tuser),
      .sensor_raw           (req_tdata[A-1:0]),
      .target_angle         ($signed(req_tdata[2*A-1:A])),
      .car_speed            ($signed(req_tdata[2*A+SPEED_W-1:2*A])),
      .angle_offset         (angle_offset_ff),
      .steps_per_rev_geared (steps_per_rev_ff),
      .speed_threshold      (speed_threshold_ff),
      .target_deadband      (target_deadband_ff),
      .small_move_threshold (small_move_ff),
      .stall_limit          (stall_limit_ff),
      .max_error            (max_error_ff),
      .flags_ff             (s1_flags),
      .prod_cur_ff          (s1_prod_cur),
      .prod_err_ff          (s1_prod_err)
   );

   spc_corr #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_corr (
      .flags          (s1_flags),
      .prod_cur       (s1_prod_cur),
      .prod_err       (s1_prod_err),
      .max_correction (max_correction_ff),
      .actual_steps   (actual_steps),
      .target_steps   (target_steps)
   );

   assign hold_current = s1_flags.motor_enabled ? HOLD_CURRENT_ON : CURRENT_OFF;
   assign run_current  = s1_flags.motor_enabled ? RUN_CURRENT_ON  : CURRENT_OFF;

   assign rsp_data_in = RSP_DATA_W'({target_steps, actual_steps, run_current, hold_current,
                                     s1_flags.motor_enabled});
   assign rsp_user_in = {s1_flags.set_target, s1_flags.set_actual, s1_flags.current_update};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
